// ===== rtl/tcc_pkg.sv =====
// tcc_pkg: shared types and constants for the turn counting cut controller
// word layouts for the sample and result channels, register codes, defaults
// no dependencies
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int unsigned OnCountDef    = 20;
  localparam int unsigned OffCountDef   = 10;
  localparam int unsigned DelayScaleDef = 10;

  localparam int unsigned FiltW  = 5;
  localparam int unsigned CountW = 16;
  localparam int unsigned DelayW = 20;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  typedef enum logic [1:0] {
    REG_TURN_TARGET   = 2'd0,
    REG_LINE_TARGET   = 2'd1,
    REG_RESTART_DELAY = 2'd2,
    REG_NONE          = 2'd3
  } tcc_reg_t;

  typedef enum logic {
    MODE_COUNT = 1'b0,
    MODE_WAIT  = 1'b1
  } tcc_mode_t;

  typedef struct packed {
    logic turn_pin;
    logic plus_one_pin;
    logic reset_pin;
  } tcc_in_t;

  typedef struct packed {
    logic              run;
    logic              cut;
    logic [CountW-1:0] turns_now;
    logic [CountW-1:0] lines_now;
    logic [CountW-1:0] rolls_now;
  } tcc_out_t;

  typedef struct packed {
    logic [CountW-1:0] turn_target;
    logic [CountW-1:0] line_target;
    logic [CountW-1:0] restart_delay;
  } tcc_cfg_t;

endpackage

// ===== rtl/tcc_filter.sv =====
// tcc_filter: up/down integrator debounce for the turn pin
// emits one turn event per falling debounced level; uses tcc_pkg
`timescale 1ns / 1ps

module tcc_filter #(
  parameter int unsigned ON_COUNT  = tcc_pkg::OnCountDef,
  parameter int unsigned OFF_COUNT = tcc_pkg::OffCountDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic turn_pin,
  output logic turn_event
);
  import tcc_pkg::*;

  localparam logic [FiltW-1:0] OnLvl  = FiltW'(ON_COUNT);
  localparam logic [FiltW-1:0] OffLvl = FiltW'(OFF_COUNT);

  logic [FiltW-1:0] level_r, level_nxt;
  logic             deb_r, deb_nxt;

  always_comb begin
    level_nxt  = level_r;
    deb_nxt    = deb_r;
    turn_event = 1'b0;
    if (turn_pin) begin
      if (level_r < OnLvl) begin
        level_nxt = level_r + 1'b1;
        if (level_nxt == OnLvl) deb_nxt = 1'b1;
      end
    end else if (level_r != '0) begin
      level_nxt = level_r - 1'b1;
      if (level_nxt == OffLvl && deb_r) begin
        deb_nxt    = 1'b0;
        turn_event = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      deb_r   <= 1'b0;
    end else if (step) begin
      level_r <= level_nxt;
      deb_r   <= deb_nxt;
    end
  end

endmodule

// ===== rtl/tcc_ctrl.sv =====
// tcc_ctrl: run/delay control, turn counting, line and roll bookkeeping
// holds the controller state that forms the result word; uses tcc_pkg
`timescale 1ns / 1ps

module tcc_ctrl #(
  parameter int unsigned DELAY_SCALE = tcc_pkg::DelayScaleDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              turn_event,
  input  logic              plus_one_pin,
  input  logic              reset_pin,
  input  tcc_pkg::tcc_cfg_t cfg,
  output tcc_pkg::tcc_out_t result
);
  import tcc_pkg::*;

  localparam logic [DelayW-1:0] Scale = DelayW'(DELAY_SCALE);

  tcc_mode_t         mode_r, mode_nxt;
  logic [CountW-1:0] turns_r, turns_nxt;
  logic [CountW-1:0] lines_r, lines_nxt;
  logic [CountW-1:0] rolls_r, rolls_nxt;
  logic [DelayW-1:0] delay_r, delay_nxt;
  logic              cut_r, cut_nxt;
  logic              run_r, run_nxt;

  logic [CountW:0]   turn_inc;
  logic [CountW:0]   turn_limit;
  logic              count_hit;
  logic [DelayW-1:0] delay_load;

  // shared compare terms, next line count and restart delay load
  always_comb begin
    turn_inc   = {1'b0, (reset_pin ? '0 : turns_r)} + 1'b1;
    turn_limit = {1'b0, cfg.turn_target} + {{CountW{1'b0}}, plus_one_pin};
    count_hit  = (cfg.turn_target != '0) && turn_event && (turn_inc >= turn_limit);
    lines_nxt  = lines_r;
    if (mode_r == MODE_WAIT && reset_pin) lines_nxt = lines_r + 1'b1;
    delay_load = DelayW'({{(DelayW-CountW){1'b0}}, cfg.restart_delay} * Scale);
  end

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_COUNT: if (count_hit) mode_nxt = MODE_WAIT;
      MODE_WAIT:  if (reset_pin) mode_nxt = MODE_COUNT;
      default:    mode_nxt = MODE_COUNT;
    endcase
  end

  // datapath
  always_comb begin
    turns_nxt = reset_pin ? '0 : turns_r;
    cut_nxt   = reset_pin ? 1'b0 : cut_r;
    run_nxt   = run_r;
    delay_nxt = delay_r;
    rolls_nxt = rolls_r;

    if (turn_event) begin
      run_nxt = 1'b0;
    end else if (delay_r != '0) begin
      delay_nxt = delay_r - 1'b1;
      if (delay_nxt == '0) run_nxt = 1'b1;
    end

    unique case (mode_r)
      MODE_COUNT: begin
        if (cfg.turn_target != '0 && turn_event) begin
          if (count_hit) cut_nxt = 1'b1;
          turns_nxt = turn_inc[CountW] ? '1 : turn_inc[CountW-1:0];
        end
      end
      MODE_WAIT: begin
        if (reset_pin) begin
          if (lines_nxt == cfg.line_target) rolls_nxt = rolls_r + 1'b1;
          if (lines_nxt < cfg.line_target) delay_nxt = delay_load;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_COUNT;
      turns_r <= '0;
      lines_r <= '0;
      rolls_r <= '0;
      delay_r <= '0;
      cut_r   <= 1'b0;
      run_r   <= 1'b0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      turns_r <= turns_nxt;
      lines_r <= lines_nxt;
      rolls_r <= rolls_nxt;
      delay_r <= delay_nxt;
      cut_r   <= cut_nxt;
      run_r   <= run_nxt;
    end
  end

  assign result.run       = run_r;
  assign result.cut       = cut_r;
  assign result.turns_now = turns_r;
  assign result.lines_now = lines_r;
  assign result.rolls_now = rolls_r;

endmodule

// ===== rtl/turn_counting_cut_controller_core.sv =====
// turn_counting_cut_controller_core: top level of the turn counting cut controller
// input word register, register file, debounce filter and controller
// depends on tcc_pkg, tcc_filter, tcc_ctrl
//
// usage:
//   in_data carries one pin sample word (turn, plus-one, reset) per tick; it is
//   taken when in_valid is high and in_stall is low, into an input register.
//   the filter and controller update from that register unless held by out_stall,
//   and the result word (run, cut, turns, lines, rolls) appears on out_data with
//   out_valid once the controller state registers have taken that update.
//   throughput is one word per cycle while out_stall is low; the state update from
//   the input register into the controller state sets that figure.
//   while out_valid and out_stall are both high the result holds and the state
//   does not advance; once the input register is also full, in_stall goes high.
//   the three 16-bit registers sit at byte addresses 0, 4, 8 on the apb port
//   and should be written only while no word is in flight.
//   reset (rst_n low, synchronous) clears config, state and valid flags, not in_r.
`timescale 1ns / 1ps

module turn_counting_cut_controller_core #(
  parameter int unsigned ON_COUNT    = tcc_pkg::OnCountDef,
  parameter int unsigned OFF_COUNT   = tcc_pkg::OffCountDef,
  parameter int unsigned DELAY_SCALE = tcc_pkg::DelayScaleDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tcc_pkg::tcc_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tcc_pkg::tcc_out_t         out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tcc_pkg::AddrW-1:0] paddr,
  input  logic [tcc_pkg::DataW-1:0] pwdata,
  output logic [tcc_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import tcc_pkg::*;

  tcc_in_t  in_r;
  logic     in_valid_r, in_valid_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     step;
  logic     turn_event;
  tcc_cfg_t cfg_r, cfg_nxt;
  tcc_reg_t reg_sel;
  logic     wr_en;

  // handshake
  assign step          = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = in_valid_r && !step;
  assign in_valid_nxt  = (in_valid && !in_stall) || (in_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_data;
  end

  // register file
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = tcc_reg_t'(paddr[AddrW-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_TURN_TARGET:   cfg_nxt.turn_target   = pwdata[CountW-1:0];
        REG_LINE_TARGET:   cfg_nxt.line_target   = pwdata[CountW-1:0];
        REG_RESTART_DELAY: cfg_nxt.restart_delay = pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TURN_TARGET:   prdata = DataW'(cfg_r.turn_target);
      REG_LINE_TARGET:   prdata = DataW'(cfg_r.line_target);
      REG_RESTART_DELAY: prdata = DataW'(cfg_r.restart_delay);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else        cfg_r <= cfg_nxt;
  end

  tcc_filter #(
    .ON_COUNT  (ON_COUNT),
    .OFF_COUNT (OFF_COUNT)
  ) u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .turn_pin   (in_r.turn_pin),
    .turn_event (turn_event)
  );

  tcc_ctrl #(
    .DELAY_SCALE (DELAY_SCALE)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .turn_event   (turn_event),
    .plus_one_pin (in_r.plus_one_pin),
    .reset_pin    (in_r.reset_pin),
    .cfg          (cfg_r),
    .result       (out_data)
  );

  assign out_valid = out_valid_r;

endmodule
